FILE: rtl/core/trle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
`timescale 1ns / 1ps
`default_nettype none

package trle_pkg;

    localparam int unsigned PIXEL_W  = 32;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned BPP_W    = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // Packet header fields
    localparam logic [6:0] COUNT_MASK = 7'd127;
    localparam int unsigned RUN_FLAG_BIT = 7;
    localparam logic [COUNT_W-1:0] MAX_PACKET = 8'd128;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_PIXELS    = 2'd1;

    // One expansion command from the parser to the emitter
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [COUNT_W-1:0] count;   // 1..128 output pixels
        logic               done;    // last pixel of this command ends the image
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/trle_front.sv
// Packet parser: takes stream bytes, assembles pixels and issues expansion commands.
`timescale 1ns / 1ps
`default_nettype none

module trle_front (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [2:0]               bytes_per_pixel,
    input  wire logic [31:0]              image_pixels,
    input  wire logic                     byte_valid,
    input  wire logic [7:0]               byte_data,
    input  wire logic                     queue_full,
    output logic                          byte_ready,
    output logic                          cmd_push,
    output trle_pkg::cmd_t                cmd_data
);
    import trle_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_RUN,
        PH_RAW
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  left_reg, left_next;
    logic [1:0]          pos_reg, pos_next;
    logic [PIXEL_W-1:0]  asm_reg, asm_next;
    logic [31:0]         written_reg, written_next;

    logic                accept;
    logic [2:0]          bpp_eff;
    logic [PIXEL_W-1:0]  asm_new;
    logic [31:0]         rem;
    logic                rem_zero;
    logic [COUNT_W-1:0]  emit;
    logic                done;
    logic [COUNT_W-1:0]  left_after;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;

    // Clamp the pixel size to 1..4 bytes
    always_comb begin
        if (bytes_per_pixel == 3'd0) begin
            bpp_eff = 3'd1;
        end else if (bytes_per_pixel > 3'd4) begin
            bpp_eff = 3'd4;
        end else begin
            bpp_eff = bytes_per_pixel;
        end
    end

    assign asm_new  = asm_reg | (PIXEL_W'(byte_data) << {pos_reg, 3'b000});
    assign rem      = image_pixels - written_reg;
    assign rem_zero = (rem == 32'd0);

    // Pixels to emit for a completed pixel, and whether the image ends
    always_comb begin
        if (phase_reg == PH_RUN) begin
            if (!rem_zero && (rem < 32'(left_reg))) begin
                emit = rem[COUNT_W-1:0];
            end else begin
                emit = left_reg;
            end
            left_after = '0;
        end else begin
            emit       = 8'd1;
            left_after = (left_reg != '0) ? left_reg - 8'd1 : '0;
        end
        done = !rem_zero && (32'(emit) == rem);
    end

    // Next-state logic
    always_comb begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        pos_next     = pos_reg;
        asm_next     = asm_reg;
        written_next = written_reg;
        cmd_push     = 1'b0;
        cmd_data.pixel = asm_new;
        cmd_data.count = emit;
        cmd_data.done  = done;
        if (accept) begin
            unique case (phase_reg)
                PH_RUN, PH_RAW: begin
                    if (({1'b0, pos_reg} + 3'd1) < bpp_eff) begin
                        pos_next = pos_reg + 2'd1;
                        asm_next = asm_new;
                    end else begin
                        cmd_push = 1'b1;
                        pos_next = 2'd0;
                        asm_next = '0;
                        left_next = left_after;
                        if (done) begin
                            written_next = '0;
                            phase_next   = PH_HEADER;
                            left_next    = '0;
                        end else begin
                            written_next = written_reg + 32'(emit);
                            if (left_after == '0) begin
                                phase_next = PH_HEADER;
                            end
                        end
                    end
                end
                default: begin
                    // Header byte: load count and packet kind
                    left_next  = {1'b0, byte_data[6:0] & COUNT_MASK} + 8'd1;
                    phase_next = byte_data[RUN_FLAG_BIT] ? PH_RUN : PH_RAW;
                    pos_next   = 2'd0;
                    asm_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            left_reg    <= '0;
            pos_reg     <= 2'd0;
            asm_reg     <= '0;
            written_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            pos_reg     <= pos_next;
            asm_reg     <= asm_next;
            written_reg <= written_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/trle_fifo.sv
// Short command queue between the packet parser and the pixel emitter.
`timescale 1ns / 1ps
`default_nettype none

module trle_fifo #(
    parameter int unsigned ADDR_W = 2
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  trle_pkg::cmd_t      push_data,
    input  wire logic           pop,
    output logic                full,
    output logic                not_empty,
    output trle_pkg::cmd_t      head
);
    import trle_pkg::*;

    localparam int unsigned DEPTH = 1 << ADDR_W;

    cmd_t              mem [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [ADDR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == (ADDR_W+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/trle_back.sv
// Pixel emitter: expands each command into results of one or two copies.
`timescale 1ns / 1ps
`default_nettype none

module trle_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cmd_valid,
    input  trle_pkg::cmd_t      cmd_head,
    output logic                cmd_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [31:0]         out_pixel,
    output logic [1:0]          out_copies,
    output logic                out_last,
    output logic                out_done
);
    import trle_pkg::*;

    logic               active_reg;
    cmd_t               cmd_reg;
    logic [COUNT_W-1:0] left_reg;
    logic               xfer;

    assign out_valid  = active_reg;
    assign out_pixel  = cmd_reg.pixel;
    assign out_copies = (left_reg >= 8'd2) ? 2'd2 : 2'd1;
    assign out_last   = (left_reg <= 8'd2);
    assign out_done   = out_last && cmd_reg.done;
    assign xfer       = active_reg && out_ready;
    assign cmd_pop    = cmd_valid && (!active_reg || (xfer && out_last));

    // Load the next command or step through the current one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            left_reg   <= '0;
        end else begin
            if (cmd_pop) begin
                active_reg <= 1'b1;
                left_reg   <= cmd_head.count;
            end else if (xfer) begin
                if (out_last) begin
                    active_reg <= 1'b0;
                end else begin
                    left_reg <= left_reg - 8'd2;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            cmd_reg <= cmd_head;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder.
// Bytes of a TGA run-length packet stream enter one per cycle on s_; a header
// byte or a pixel byte that does not end a pixel yields no result. A finished
// pixel becomes a command in a small queue, and the emitter drains it at one
// result per cycle while m_tready is high: a raw pixel gives one result, a run
// of n pixels gives ceil(n/2) results of two copies (one copy at an odd tail),
// so a 128-pixel run gives 64 results. The input stalls only when the queue is
// full. Output stops at image_pixels; the remainder of that packet is dropped
// and the next byte is read as a header. Configuration writes are taken every
// cycle and belong while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_pixel_decoder #(
    parameter int unsigned QUEUE_ADDR_W = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] data_byte
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,     // [31:0] pixel, [33:32] copies, rest zero
    output logic             m_tlast,     // last_of_input
    output logic             m_tuser,     // [0] image_done
    // Configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [trle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);
    import trle_pkg::*;

    logic [BPP_W-1:0] bpp_reg;
    logic [31:0]      image_pixels_reg;

    logic   queue_full;
    logic   queue_not_empty;
    logic   cmd_push;
    logic   cmd_pop;
    cmd_t   cmd_in;
    cmd_t   cmd_head;
    logic [31:0] out_pixel;
    logic [1:0]  out_copies;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg          <= 3'd3;
            image_pixels_reg <= 32'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BYTES_PER_PIXEL: bpp_reg          <= cfg_data[BPP_W-1:0];
                REG_IMAGE_PIXELS:    image_pixels_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    trle_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .bytes_per_pixel (bpp_reg),
        .image_pixels    (image_pixels_reg),
        .byte_valid      (s_tvalid),
        .byte_data       (s_tdata),
        .queue_full      (queue_full),
        .byte_ready      (s_tready),
        .cmd_push        (cmd_push),
        .cmd_data        (cmd_in)
    );

    trle_fifo #(
        .ADDR_W (QUEUE_ADDR_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (cmd_in),
        .pop       (cmd_pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (cmd_head)
    );

    trle_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (queue_not_empty),
        .cmd_head   (cmd_head),
        .cmd_pop    (cmd_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pixel  (out_pixel),
        .out_copies (out_copies),
        .out_last   (m_tlast),
        .out_done   (m_tuser)
    );

    assign m_tdata = {6'd0, out_copies, out_pixel};

endmodule

`default_nettype wire

FILE: tb/tga_rle_pixel_decoder_test.sv
// Self-checking stream testbench for the TGA run-length pixel decoder.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_test;
    import trle_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned LONG_HOLD     = 300;

    // Indexes that map to no register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic [1:0] {PH_HEADER, PH_RUN, PH_RAW} parse_phase_t;

    typedef struct {
        logic [31:0] pixel;
        logic [1:0]  copies;
        logic        last_of_input;
        logic        image_done;
    } pixel_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [39:0]          m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    tga_rle_pixel_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Decoder state as predicted by the testbench (reset values)
    logic [2:0]   bpp_reg     = 3'd3;
    logic [31:0]  total_reg   = 32'd1;
    parse_phase_t parse_phase = PH_HEADER;
    int unsigned  packet_left = 0;
    int unsigned  byte_pos    = 0;
    logic [31:0]  pixel_acc   = '0;
    logic [31:0]  pixels_out  = '0;

    logic [7:0]    byte_feed_q[$];
    pixel_result_t pixel_expect_q[$];

    int unsigned items_queued  = 0;
    int unsigned items_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned images_seen   = 0;
    int unsigned settings_used = 1;
    int unsigned errors        = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_gap      = 0;
    int unsigned hold_ask      = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned stall_left    = 0;

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Register code to pixel size: zero reads as one, above four as four
    function automatic int unsigned pixel_size(input logic [2:0] code);
        if (code == 3'd0) return 1;
        if (code > 3'd4) return 4;
        return int'(code);
    endfunction

    task automatic rearm_header();
        parse_phase = PH_HEADER;
        packet_left = 0;
        byte_pos    = 0;
        pixel_acc   = '0;
    endtask

    // Advance the predicted decoder by one stream byte and queue its results
    task automatic expand_byte(input logic [7:0] b);
        int unsigned     size;
        logic [31:0]     left32;
        longint unsigned room, emit, i;
        logic            done;
        pixel_result_t   r;
        size = pixel_size(bpp_reg);
        if (parse_phase == PH_HEADER) begin
            packet_left = int'(b & {1'b0, COUNT_MASK}) + 1;
            parse_phase = b[RUN_FLAG_BIT] ? PH_RUN : PH_RAW;
            byte_pos    = 0;
            pixel_acc   = '0;
            return;
        end
        pixel_acc = pixel_acc | ({24'd0, b} << (8 * byte_pos));
        if (byte_pos + 1 < size) begin
            byte_pos++;
            return;
        end
        // Pixels still allowed in this image; zero stands for 2^32
        left32 = total_reg - pixels_out;
        room   = (left32 == '0) ? 64'h1_0000_0000 : {32'd0, left32};
        if (parse_phase == PH_RUN) begin
            emit = packet_left;
            if (emit > room) emit = room;
            packet_left = 0;
        end else begin
            emit = 1;
            packet_left = (packet_left > 0) ? packet_left - 1 : 0;
        end
        done = (emit == room);
        for (i = 0; i < emit; i += 2) begin
            r.pixel         = pixel_acc;
            r.copies        = (emit - i >= 2) ? 2'd2 : 2'd1;
            r.last_of_input = (i + r.copies >= emit);
            r.image_done    = r.last_of_input && done;
            pixel_expect_q.push_back(r);
        end
        if (done) begin
            pixels_out = '0;
            rearm_header();
        end else begin
            pixels_out = pixels_out + emit[31:0];
            if (packet_left == 0) begin
                rearm_header();
            end else begin
                byte_pos  = 0;
                pixel_acc = '0;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        byte_feed_q.push_back(b);
        items_queued++;
    endtask

    // Hold until every queued byte is taken and every result has drained
    task automatic wait_quiet();
        while (items_taken != items_queued || pixel_expect_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data,
                             input bit keep);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_BYTES_PER_PIXEL: bpp_reg   = data[2:0];
            REG_IMAGE_PIXELS:    total_reg = data;
            default: ;
        endcase
        if (!keep) cfg_valid <= 1'b0;
    endtask

    // Write both registers back to back; upper bits of the size word are junk
    task automatic configure(input logic [2:0] bpp, input logic [31:0] total);
        write_reg(REG_BYTES_PER_PIXEL, ($urandom() & ~32'h7) | {29'd0, bpp}, 1'b1);
        write_reg(REG_IMAGE_PIXELS, total, 1'b0);
        settings_used++;
    endtask

    // Well-formed packets with random content, salted with stray bytes
    task automatic gen_packets(input int unsigned nbytes);
        int unsigned start, size, cnt, npix;
        logic        run;
        start = items_queued;
        size  = pixel_size(bpp_reg);
        while (items_queued - start < nbytes) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom()));
            end else begin
                run = 1'($urandom_range(0, 1));
                if (run)
                    cnt = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7)
                                                       : $urandom_range(8, 127);
                else
                    cnt = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 5)
                                                       : $urandom_range(6, 15);
                npix = run ? 1 : cnt + 1;
                push_byte({run, 7'(cnt)});
                repeat (npix * size) push_byte(8'($urandom()));
            end
        end
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Offer queued bytes; predict each one at its transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expand_byte(s_tdata);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (byte_feed_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= byte_feed_q.pop_front();
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin : result_check
        pixel_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser) images_seen++;
            if (pixel_expect_q.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual %h %b %b",
                         $time, m_tdata, m_tlast, m_tuser);
            end else begin
                want = pixel_expect_q.pop_front();
                check_field("pixel", want.pixel, m_tdata[31:0]);
                check_field("copies", {30'd0, want.copies}, {30'd0, m_tdata[33:32]});
                check_field("last_of_input", {31'd0, want.last_of_input}, {31'd0, m_tlast});
                check_field("image_done", {31'd0, want.image_done}, {31'd0, m_tuser});
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pixel_expect_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: 3-byte pixels, one pixel per image; the run is cut to one
        push_byte(8'h85);
        push_byte(8'h00); push_byte(8'hFF); push_byte(8'hA5);
        // Raw packet of two ends the image after its first pixel
        push_byte(8'h01);
        push_byte(8'h5A); push_byte(8'hC3); push_byte(8'h3C);
        wait_quiet();

        // Widest pixel, endless image: longest run and all-ones bytes
        configure(3'd4, 32'd0);
        push_byte(8'hFF);
        repeat (4) push_byte(8'hFF);
        // Shrink the pixel size with two bytes of a pixel already gathered
        push_byte(8'h00); push_byte(8'h11); push_byte(8'h22);
        wait_quiet();
        write_reg(REG_BYTES_PER_PIXEL, 32'd2, 1'b0);
        settings_used++;
        push_byte(8'h33);
        wait_quiet();

        // Longest raw packet truncated by a small image, then a run with an odd tail
        configure(3'd1, 32'd5);
        push_byte(8'h7F);
        repeat (5) push_byte(8'($urandom()));
        push_byte(8'h82);
        push_byte(8'($urandom()));
        wait_quiet();

        // Fill the block while the receiver holds off
        configure(3'd1, 32'd1000);
        hold_ask++;
        push_byte(8'h27);
        repeat (40) push_byte(8'($urandom()));
        gen_packets(10);
        wait_quiet();

        configure(3'd0, $urandom_range(1, 40));
        gen_packets(10);
        wait_quiet();

        configure(3'd7, 32'hFFFF_FFFF);
        gen_packets(10);
        wait_quiet();

        write_reg(REG_SPARE_2, $urandom(), 1'b1);
        write_reg(REG_SPARE_3, $urandom(), 1'b1);
        configure(3'd2, $urandom_range(1, 300));
        gen_packets(10);
        wait_quiet();

        configure(3'd5, 32'd2);
        gen_packets(10);
        wait_quiet();

        configure(3'd4, $urandom_range(50, 500));
        gen_packets(10);
        wait_quiet();

        $display("Sent %0d stream bytes under %0d register settings;", items_taken,
                 settings_used);
        $display("checked %0d result transfers, %0d of them closing an image.",
                 results_seen, images_seen);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/trle_pkg.sv
rtl/core/trle_front.sv
rtl/core/trle_fifo.sv
rtl/core/trle_back.sv
rtl/core/tga_rle_pixel_decoder.sv
tb/tga_rle_pixel_decoder_test.sv
